### rtl/tca_pkg.sv
// Shared constants, register codes and pipeline types for the texel address block.
package tca_pkg;

   // Field widths
   localparam int ColumnWidth  = 12;
   localparam int RowWidth     = 12;
   localparam int LineHtWidth  = 16;
   localparam int TexColWidth  = 6;
   localparam int TexIdxWidth  = 2;
   localparam int TexRowWidth  = 6;
   localparam int TexOffWidth  = 18;
   localparam int FrameWidth   = 26;
   localparam int CsrWidth     = 13;
   localparam int TexelBitsW   = 6;
   localparam int CsrIndexW    = 3;

   // Texture side is a power of two; row and column wrap on it
   localparam int TexSizeLog2  = 6;

   // Signed slice numerator and the divider dividend (|num| / 4)
   localparam int NumerWidth   = 25;
   localparam int DvdWidth     = 22;
   localparam int BitsPerStage = 2;
   localparam int DivStages    = DvdWidth / BitsPerStage;

   // Pixel offset before the 4-byte scale, texel column term width
   localparam int FrameSumW    = FrameWidth - 2;
   localparam int TexTermW     = TexColWidth + TexelBitsW - 3;

   // Register indexes
   localparam logic [CsrIndexW-1:0] CsrScreenWidth  = 3'd0;
   localparam logic [CsrIndexW-1:0] CsrScreenHeight = 3'd1;
   localparam logic [CsrIndexW-1:0] CsrRowBytesN    = 3'd2;
   localparam logic [CsrIndexW-1:0] CsrRowBytesS    = 3'd3;
   localparam logic [CsrIndexW-1:0] CsrRowBytesW    = 3'd4;
   localparam logic [CsrIndexW-1:0] CsrRowBytesE    = 3'd5;
   localparam logic [CsrIndexW-1:0] CsrTexelBits    = 3'd6;

   // Reset values of the registers
   localparam logic [CsrWidth-1:0]   ScreenWidthRst  = 13'd640;
   localparam logic [CsrWidth-1:0]   ScreenHeightRst = 13'd480;
   localparam logic [CsrWidth-1:0]   RowBytesRst     = 13'd256;
   localparam logic [TexelBitsW-1:0] TexelBitsRst    = 6'd32;

   // First stage: numerator and frame sum formed
   typedef struct packed {
      logic [TexIdxWidth-1:0]       idx;
      logic                         last;
      logic [LineHtWidth-1:0]       lh;
      logic signed [NumerWidth-1:0] numer;
      logic [FrameSumW-1:0]         frame_sum;
      logic [TexTermW-1:0]          tex_term;
   } front_type;

   // Divider stages: remainder and dividend that turns into the quotient
   typedef struct packed {
      logic [TexIdxWidth-1:0] idx;
      logic                   last;
      logic [LineHtWidth-1:0] lh;
      logic [LineHtWidth-1:0] rem;
      logic [DvdWidth-1:0]    dvd;
      logic [FrameSumW-1:0]   frame_sum;
      logic [TexTermW-1:0]    tex_term;
   } div_type;

endpackage

### rtl/tca_req_if.sv
// Request channel: one screen pixel of a wall slice.
interface tca_req_if;
   import tca_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ColumnWidth-1:0] column;
   logic [RowWidth-1:0]    row;
   logic [LineHtWidth-1:0] line_height;
   logic [TexColWidth-1:0] tex_column;
   logic                   wall_axis;
   logic                   ray_dir_nonneg;
   logic                   last_row;

   modport source (
      output valid, column, row, line_height, tex_column, wall_axis, ray_dir_nonneg,
             last_row,
      input  ready
   );

   modport sink (
      input  valid, column, row, line_height, tex_column, wall_axis, ray_dir_nonneg,
             last_row,
      output ready
   );
endinterface

### rtl/tca_rsp_if.sv
// Response channel: texture choice, texel offset and framebuffer offset.
interface tca_rsp_if;
   import tca_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [TexIdxWidth-1:0] texture_index;
   logic [TexRowWidth-1:0] tex_row;
   logic [TexOffWidth-1:0] texel_offset;
   logic [FrameWidth-1:0]  frame_offset;
   logic                   slice_end;

   modport source (
      output valid, texture_index, tex_row, texel_offset, frame_offset, slice_end,
      input  ready
   );

   modport sink (
      input  valid, texture_index, tex_row, texel_offset, frame_offset, slice_end,
      output ready
   );
endinterface

### rtl/textured_column_texel_address.sv
// Top level: pipelined texel and framebuffer addressing for raycast wall slices.
//
//   port group   dir   content
//   ----------   ---   ------------------------------------------------------
//   req_bus      in    column, row, line_height, tex_column, axis, sign, last
//   rsp_bus      out   texture_index, tex_row, texel_offset, frame_offset, end
//   csr_*        in    write enable, register index, 13-bit write data
//
// One request per clock unless stalled. Stages: a front stage (numerator, frame
// multiply), an absolute-value stage, 11 divider stages of 2 quotient bits each
// (22-bit restoring division by line height), and the output register.
// Reset is synchronous and clears valid bits and config registers to defaults.
// Each stage has its own ready (empty or draining), so bubbles close up under
// a stalled response and nothing is dropped or repeated.
module textured_column_texel_address (
   input  logic                            clock,
   input  logic                            reset,
   tca_req_if.sink                         req_bus,
   tca_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [tca_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [tca_pkg::CsrWidth-1:0]    csr_wdata
);
   import tca_pkg::*;

   // Configuration registers
   logic [CsrWidth-1:0]   screen_width_ff;
   logic [CsrWidth-1:0]   screen_height_ff;
   logic [CsrWidth-1:0]   row_bytes_ff [4];
   logic [TexelBitsW-1:0] texel_bits_ff;

   // Pipeline state
   logic                  front_v_ff;
   front_type             front_ff;
   front_type             front_in;
   logic [DivStages:0]    div_v_ff;
   div_type               div_ff [DivStages+1];
   div_type               div_in [DivStages+1];
   logic                  out_v_ff;

   // Stage enables
   logic                  front_en;
   logic [DivStages:0]    div_en;
   logic                  out_en;

   // Output payload
   logic [TexIdxWidth-1:0] out_idx_ff;
   logic [TexRowWidth-1:0] out_row_ff;
   logic [TexOffWidth-1:0] out_toff_ff;
   logic [FrameWidth-1:0]  out_foff_ff;
   logic                   out_end_ff;
   logic [TexOffWidth-1:0] out_toff_in;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= ScreenWidthRst;
         screen_height_ff <= ScreenHeightRst;
         row_bytes_ff[0]  <= RowBytesRst;
         row_bytes_ff[1]  <= RowBytesRst;
         row_bytes_ff[2]  <= RowBytesRst;
         row_bytes_ff[3]  <= RowBytesRst;
         texel_bits_ff    <= TexelBitsRst;
      end else if (csr_we) begin
         case (csr_index)
            CsrScreenWidth:  screen_width_ff  <= csr_wdata;
            CsrScreenHeight: screen_height_ff <= csr_wdata;
            CsrRowBytesN:    row_bytes_ff[0]  <= csr_wdata;
            CsrRowBytesS:    row_bytes_ff[1]  <= csr_wdata;
            CsrRowBytesW:    row_bytes_ff[2]  <= csr_wdata;
            CsrRowBytesE:    row_bytes_ff[3]  <= csr_wdata;
            CsrTexelBits:    texel_bits_ff    <= csr_wdata[TexelBitsW-1:0];
            default: ;
         endcase
      end
   end

   // Ready ripple from the output back to the request side
   always_comb begin
      out_en            = !out_v_ff || rsp_bus.ready;
      div_en[DivStages] = !div_v_ff[DivStages] || out_en;
      for (int k = DivStages - 1; k >= 0; k--) begin
         div_en[k] = !div_v_ff[k] || div_en[k+1];
      end
      front_en = !front_v_ff || div_en[0];
   end

   assign req_bus.ready = front_en;

   // Front stage: slice numerator, frame multiply, texel column term
   always_comb begin
      logic [LineHtWidth-1:0]           lh;
      logic [2*CsrWidth-1:0]            fprod;
      logic [TexColWidth+TexelBitsW-1:0] tprod;
      lh    = (req_bus.line_height == '0) ? LineHtWidth'(1) : req_bus.line_height;
      fprod = screen_width_ff * {1'b0, req_bus.row};
      tprod = req_bus.tex_column[TexSizeLog2-1:0] * texel_bits_ff;
      front_in.idx       = {req_bus.wall_axis, req_bus.ray_dir_nonneg};
      front_in.last      = req_bus.last_row;
      front_in.lh        = lh;
      front_in.numer     = $signed({5'b0, req_bus.row, 8'b0}
                                   + {2'b0, lh, 7'b0}
                                   - {5'b0, screen_height_ff, 7'b0});
      front_in.frame_sum = FrameSumW'(fprod + {{(2*CsrWidth-ColumnWidth){1'b0}},
                                               req_bus.column});
      front_in.tex_term  = tprod[TexColWidth+TexelBitsW-1:3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else if (front_en) begin
         front_v_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         front_ff <= front_in;
      end
   end

   // Magnitude stage: |num| / 4 is the dividend (the sign drops out)
   always_comb begin
      logic [NumerWidth-1:0] mag;
      mag = front_ff.numer[NumerWidth-1] ? NumerWidth'(-front_ff.numer)
                                          : NumerWidth'(front_ff.numer);
      div_in[0].idx       = front_ff.idx;
      div_in[0].last      = front_ff.last;
      div_in[0].lh        = front_ff.lh;
      div_in[0].rem       = '0;
      div_in[0].dvd       = mag[DvdWidth+1:2];
      div_in[0].frame_sum = front_ff.frame_sum;
      div_in[0].tex_term  = front_ff.tex_term;
   end

   // Divider stages: restoring division, quotient shifts into dvd
   for (genvar k = 1; k <= DivStages; k++) begin : g_div
      always_comb begin
         div_type              cur;
         logic [LineHtWidth:0] trial;
         cur = div_ff[k-1];
         for (int b = 0; b < BitsPerStage; b++) begin
            trial = {cur.rem, cur.dvd[DvdWidth-1]};
            if (trial >= {1'b0, cur.lh}) begin
               cur.rem = LineHtWidth'(trial - {1'b0, cur.lh});
               cur.dvd = {cur.dvd[DvdWidth-2:0], 1'b1};
            end else begin
               cur.rem = trial[LineHtWidth-1:0];
               cur.dvd = {cur.dvd[DvdWidth-2:0], 1'b0};
            end
         end
         div_in[k] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_v_ff <= '0;
      end else begin
         if (div_en[0]) begin
            div_v_ff[0] <= front_v_ff;
         end
         for (int k = 1; k <= DivStages; k++) begin
            if (div_en[k]) begin
               div_v_ff[k] <= div_v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= DivStages; k++) begin
         if (div_en[k]) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // Output stage: texel offset from texture row and row pitch
   always_comb begin
      logic [TexRowWidth+CsrWidth:0] sum;
      sum = (TexRowWidth+CsrWidth+1)'(div_ff[DivStages].dvd[TexSizeLog2-1:0]
                                      * row_bytes_ff[div_ff[DivStages].idx])
          + (TexRowWidth+CsrWidth+1)'(div_ff[DivStages].tex_term);
      out_toff_in = sum[TexOffWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_en) begin
         out_v_ff <= div_v_ff[DivStages];
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         out_idx_ff  <= div_ff[DivStages].idx;
         out_row_ff  <= div_ff[DivStages].dvd[TexSizeLog2-1:0];
         out_toff_ff <= out_toff_in;
         out_foff_ff <= {div_ff[DivStages].frame_sum, 2'b00};
         out_end_ff  <= div_ff[DivStages].last;
      end
   end

   assign rsp_bus.valid         = out_v_ff;
   assign rsp_bus.texture_index = out_idx_ff;
   assign rsp_bus.tex_row       = out_row_ff;
   assign rsp_bus.texel_offset  = out_toff_ff;
   assign rsp_bus.frame_offset  = out_foff_ff;
   assign rsp_bus.slice_end     = out_end_ff;

`ifndef NO_ASSERTIONS
   // Requests are only held off when the front stage is full
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> front_v_ff)
      else $error("request stalled with an empty front stage");

   // Zero line height never reaches the divider
   a_lh_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_v_ff[0] |-> (div_ff[0].lh != '0))
      else $error("zero divisor in divider");

   // Final remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      div_v_ff[DivStages] |-> (div_ff[DivStages].rem < div_ff[DivStages].lh))
      else $error("divider remainder out of range");

   // A write to an unused index leaves every register alone
   a_bad_index: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_index > CsrTexelBits)) |=>
         ($stable(screen_width_ff) && $stable(screen_height_ff)
          && $stable(row_bytes_ff[0]) && $stable(row_bytes_ff[1])
          && $stable(row_bytes_ff[2]) && $stable(row_bytes_ff[3])
          && $stable(texel_bits_ff)))
      else $error("register changed on an unused index");
`endif

endmodule
